[hdl/oabp_pkg.sv]
`timescale 1ns / 1ps
package oabp_pkg;
  localparam int SAMPLE_WORDS_DEF = 65536;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic signed [17:0] SAT_POS = 18'sd32767;
  localparam logic signed [17:0] SAT_NEG = -18'sd32767;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_ENQUEUE = 2'd1,
    MODE_CURSOR  = 2'd2,
    MODE_FETCH   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] frames;
    logic [15:0] align;
    logic        stereo;
  } desc_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DESC, S_DWAIT, S_EVAL, S_RD0, S_RD1, S_RD2, S_RD3, S_MIX, S_OUT
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > SAT_POS) return 16'sd32767;
    if (v < SAT_NEG) return -16'sd32767;
    return v[15:0];
  endfunction
endpackage

[hdl/oabp_sample_mem.sv]
`timescale 1ns / 1ps
module oabp_sample_mem #(
  parameter int SAMPLE_WORDS = 65536,
  localparam int AW = $clog2(SAMPLE_WORDS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);
  logic [15:0] mem [SAMPLE_WORDS];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[hdl/oabp_desc_ring.sv]
`timescale 1ns / 1ps
module oabp_desc_ring #(
  parameter int QUEUE_DEPTH = 16,
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [QW-1:0]  waddr_i,
  input  oabp_pkg::desc_t wdata_i,
  input  logic [QW-1:0]  raddr_i,
  output oabp_pkg::desc_t rdata_o
);
  import oabp_pkg::*;
  desc_t mem [QUEUE_DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[hdl/overlapping_audio_buffer_player.sv]
`timescale 1ns / 1ps
// Channel  Direction  Signals
// in       input      in_valid_i / in_ready_o, mode_i .. cursor_position_i
// out      output     out_valid_o / out_ready_i, left_sample_o .. status_o
// Write, enqueue, cursor requests: go from S_IDLE straight to S_OUT for the result.
// Fetch: walks S_DESC..S_MIX to S_OUT; each popped head buffer repeats S_DESC..S_EVAL.
// Ring and sample store are synchronous memories with one write and one read port, one read a cycle.
// Reset clears queue pointers and cursor; memories are undefined until written.
// One request in flight; in_ready_o low until the result is taken.
module overlapping_audio_buffer_player #(
  parameter int SAMPLE_WORDS = oabp_pkg::SAMPLE_WORDS_DEF,
  parameter int QUEUE_DEPTH = oabp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        mem_address_i,
  input  logic signed [15:0] mem_data_i,
  input  logic [15:0]        buffer_base_i,
  input  logic [15:0]        frame_count_i,
  input  logic [15:0]        align_frames_i,
  input  logic               is_stereo_i,
  input  logic [31:0]        cursor_position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o,
  output logic [31:0]        cursor_now_o,
  output logic [31:0]        remaining_frames_o,
  output logic [1:0]         status_o
);
  import oabp_pkg::*;
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_e state_q, state_d;
  logic [QW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0] hpos_q, hpos_d;
  logic signed [33:0] rel_q, rel_d;
  logic [31:0] qlen_q, qlen_d;
  desc_t nd_q;
  desc_t cur_q, d_d, d_cur, len_src;
  logic second_q, mix_q;
  logic signed [15:0] l_q, r_q, l2_q, r2_q;
  logic [1:0] st_q;

  desc_t ring_rd;
  logic ring_we;
  logic [QW-1:0] ring_wa, ring_ra;
  logic [AW-1:0] smp_ra;
  logic [15:0] smp_rd;
  logic smp_we;

  function automatic logic [QW-1:0] ring_idx(input logic [CW:0] v);
    if (v >= (CW+1)'(QUEUE_DEPTH)) return QW'(v - (CW+1)'(QUEUE_DEPTH));
    return QW'(v);
  endfunction

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_o;
  wire acc = in_valid_i && in_ready_o;

  assign smp_we = acc && (mode_i == MODE_WRITE);
  oabp_sample_mem #(.SAMPLE_WORDS(SAMPLE_WORDS)) u_smp (
    .clk_i, .we_i(smp_we), .waddr_i(AW'(mem_address_i)), .wdata_i(mem_data_i),
    .raddr_i(smp_ra), .rdata_o(smp_rd));

  wire full = (count_q == CW'(QUEUE_DEPTH));
  wire bad = align_frames_i > frame_count_i;
  assign ring_we = acc && (mode_i == MODE_ENQUEUE) && !full && !bad;
  assign ring_wa = ring_idx((CW+1)'(head_q) + (CW+1)'(count_q));
  assign d_d = '{base: buffer_base_i, frames: frame_count_i, align: align_frames_i,
                 stereo: is_stereo_i};
  assign ring_ra = second_q ? ring_idx((CW+1)'(head_q) + (CW+1)'(1)) : head_q;
  oabp_desc_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring (
    .clk_i, .we_i(ring_we), .waddr_i(ring_wa), .wdata_i(d_d), .raddr_i(ring_ra),
    .rdata_o(ring_rd));

  // current descriptor lengths; head descriptor comes straight from the ring on first eval
  assign len_src = (state_q == S_EVAL && !second_q) ? ring_rd : cur_q;
  wire [15:0] len = len_src.frames - len_src.align;
  wire [15:0] nxt_off = len - ring_rd.align;
  wire [31:0] rel32 = rel_q[31:0];
  wire [31:0] mpos = rel32 - {16'd0, nxt_off};
  assign d_cur = second_q ? nd_q : cur_q;
  wire [31:0] pos = second_q ? mpos : ({16'd0, cur_q.align} + rel32);
  logic odd;
  always_comb begin
    logic [32:0] off;
    off = d_cur.stereo ? {pos, odd} : {1'b0, pos};
    smp_ra = AW'({17'd0, d_cur.base} + off);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (acc) state_d = (mode_i == MODE_FETCH) ? S_DESC : S_OUT;
      S_DESC:  state_d = (rel_q < 0 || count_q == '0) ? S_OUT : S_DWAIT;
      S_DWAIT: state_d = S_EVAL;
      S_EVAL:  state_d = second_q ? S_RD2 :
                         ({18'd0, len} > rel_q) ? S_RD0 : S_DESC;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = (count_q > CW'(1)) ? S_DWAIT : S_MIX;
      S_RD2:   state_d = S_RD3;
      S_RD3:   state_d = S_MIX;
      S_MIX:   state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    odd = (state_q == S_RD1) || (state_q == S_RD3);
    head_d = head_q; count_d = count_q; hpos_d = hpos_q; rel_d = rel_q; qlen_d = qlen_q;
    if (ring_we) begin
      count_d = count_q + 1'b1;
      qlen_d = qlen_q + {16'd0, frame_count_i - align_frames_i};
    end
    if (acc && mode_i == MODE_CURSOR)
      rel_d = $signed({2'b0, cursor_position_i}) - $signed({2'b0, hpos_q});
    if (state_q == S_DESC && rel_q < 0) rel_d = rel_q + 34'sd1;
    if (state_q == S_EVAL && !second_q && !({18'd0, len} > rel_q)) begin
      head_d = ring_idx((CW+1)'(head_q) + (CW+1)'(1));
      count_d = count_q - 1'b1;
      hpos_d = hpos_q + {16'd0, len};
      rel_d = rel_q - $signed({18'd0, len});
      qlen_d = qlen_q - {16'd0, len};
    end
    if (state_q == S_MIX) rel_d = rel_q + 34'sd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; head_q <= '0; count_q <= '0; hpos_q <= '0;
      rel_q <= '0; qlen_q <= '0; out_valid_o <= 1'b0; second_q <= 1'b0; mix_q <= 1'b0;
    end else begin
      state_q <= state_d; head_q <= head_d; count_q <= count_d; hpos_q <= hpos_d;
      rel_q <= rel_d; qlen_q <= qlen_d;
      if (state_q == S_OUT) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (state_q == S_IDLE) begin
        second_q <= 1'b0; mix_q <= 1'b0;
      end
      if (state_q == S_RD1 && count_q > CW'(1)) second_q <= 1'b1;
      if (state_q == S_EVAL && second_q)
        mix_q <= (ring_rd.align <= len) && (rel32 >= {16'd0, nxt_off});
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      st_q <= (mode_i != MODE_ENQUEUE) ? ST_OK : full ? ST_FULL : bad ? ST_BAD : ST_OK;
      l_q <= '0; r_q <= '0; l2_q <= '0; r2_q <= '0;
    end
    if (state_q == S_EVAL) begin
      if (second_q) nd_q <= ring_rd;
      else cur_q <= ring_rd;
    end
    if (state_q == S_RD1) l_q <= $signed(smp_rd);
    if (state_q == S_DWAIT && second_q) r_q <= cur_q.stereo ? $signed(smp_rd) : l_q;
    if (state_q == S_RD3) l2_q <= $signed(smp_rd);
    if (state_q == S_MIX) begin
      if (!second_q) r_q <= cur_q.stereo ? $signed(smp_rd) : l_q;
      if (second_q) r2_q <= nd_q.stereo ? $signed(smp_rd) : l2_q;
    end
    if (state_q == S_OUT) begin
      left_sample_o <= mix_q ? sat16(18'(l_q) + 18'(l2_q)) : l_q;
      right_sample_o <= mix_q ? sat16(18'(r_q) + 18'(r2_q)) : r_q;
      cursor_now_o <= hpos_q + rel_q[31:0];
      status_o <= st_q;
      begin
        logic signed [34:0] rem;
        rem = $signed({3'b0, qlen_q}) - 35'(rel_q);
        remaining_frames_o <= (rem < 0) ? 32'd0 : (rem > 35'sh0FFFFFFFF) ? '1 : rem[31:0];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !out_valid_o)
    else $error("ready with pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(QUEUE_DEPTH))
    else $error("ring overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> out_valid_o) else $error("lost result");
endmodule
